// ===== src/ilir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ilir_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int WIDTH    = 32;

    // fixed field widths of the channels
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int DIN_W    = 32;
    localparam int DOUT_W   = 32;
    localparam int CNTF_W   = 7;
    localparam int STAT_W   = 2;

    // internal widths
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // read gather tree
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    typedef logic [WIDTH-1:0]  word_t;
    typedef logic [CMP_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADIDX = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_EXEC   = 2'd1,
        FSM_GATHER = 2'd2
    } fsm_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        idx_t     pos;
        word_t    data;
    } cell_cmd_t;

    // input field to stored word, zero filled above the field
    function automatic word_t to_word(input logic [DIN_W-1:0] d);
        word_t w;
        w = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (i < DIN_W)
            begin
                w[i] = d[i];
            end
        end
        return w;
    endfunction

    // stored word to output field
    function automatic logic [DOUT_W-1:0] to_dout(input word_t w);
        logic [DOUT_W-1:0] d;
        d = '0;
        for (int i = 0; i < DOUT_W; i++)
        begin
            if (i < WIDTH)
            begin
                d[i] = w[i];
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== src/ilir_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// command channel
interface ilir_req_if;
    import ilir_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [POS_W-1:0]   position;
    logic [DIN_W-1:0]   data_in;

    modport source (output valid, output command, output position, output data_in,
                    input ready);
    modport sink   (input valid, input command, input position, input data_in,
                    output ready);
endinterface

// result channel
interface ilir_rsp_if;
    import ilir_pkg::*;
    logic               valid;
    logic               ready;
    logic [DOUT_W-1:0]  data_out;
    logic [CNTF_W-1:0]  item_count;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output data_out, output item_count, output status,
                    input ready);
    modport sink   (input valid, input data_out, input item_count, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== src/ilir_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ilir_cell (
    input  wire logic               clk,
    input  wire ilir_pkg::cell_cmd_t cmd,
    input  wire ilir_pkg::idx_t      idx,
    input  wire ilir_pkg::word_t     prev_data,
    input  wire ilir_pkg::word_t     next_data,
    output ilir_pkg::word_t          data,
    output ilir_pkg::word_t          rd_data
);
    import ilir_pkg::*;

    word_t data_reg;
    word_t data_next;

    // shift up, shift down, load or hold
    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (idx == cmd.pos)
                begin
                    data_next = cmd.data;
                end
                else if (idx > cmd.pos)
                begin
                    data_next = prev_data;
                end
            end
            CELL_REMOVE:
            begin
                if (idx >= cmd.pos)
                begin
                    data_next = next_data;
                end
            end
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // word onto the read bus only where the index matches
    assign rd_data = (idx == cmd.pos) ? data_reg : '0;

endmodule
`default_nettype wire

// ===== src/ilir_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ilir_chain (
    input  wire logic                clk,
    input  wire ilir_pkg::cell_cmd_t cmd,
    output ilir_pkg::word_t          rd_word
);
    import ilir_pkg::*;

    word_t cell_data [CAPACITY];
    word_t cell_rd   [CAPACITY];
    word_t grp_reg   [NGROUP];
    word_t grp_next  [NGROUP];

    // row of cells, each linked to its neighbors; an end cell takes its own word in place of the missing one
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        word_t prev_w;
        word_t next_w;

        if (g == 0)
        begin : g_first
            assign prev_w = cell_data[0];
        end
        else
        begin : g_mid_lo
            assign prev_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_w = cell_data[g];
        end
        else
        begin : g_mid_hi
            assign next_w = cell_data[g+1];
        end

        ilir_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .idx       (CMP_W'(g)),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (cell_data[g]),
            .rd_data   (cell_rd[g])
        );
    end

    // first level of the read tree: or within each group
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | cell_rd[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    // second level: or across the groups
    always_comb
    begin
        rd_word = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            rd_word = rd_word | grp_reg[g];
        end
    end

endmodule
`default_nettype wire

// ===== src/indexed_list_insert_remove_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY words held in a row of cells.
// req carries one command per beat: append, insert at position, read at
// position or remove at position, with the word to store in data_in.
// rsp returns one beat per command: the word read (zero unless a read
// succeeds), the entry count after the command and a status code
// (ok, invalid index, list full). Bad commands change nothing.
// From the req beat to the rsp beat a command is first registered, then
// every cell shifts or loads at once and the read bus is reduced into
// group registers, then the read tree is finished into the output register.
// A new command is taken only after the previous one has left the gather
// step; req.ready is high only while no command is in flight, so one
// command is worked on at a time.
// The output register lets the next command enter while a result waits.
// If rsp stalls, the finished result is held in the gather step until the
// output register is free, and req.ready stays low until then.
// Reset clears the entry count and the control state; the stored words
// are not cleared, and only words below the count are ever read.
module indexed_list_insert_remove_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ilir_req_if.sink     req,
    ilir_rsp_if.source   rsp
);
    import ilir_pkg::*;

    fsm_t      state_reg;
    fsm_t      state_next;

    cmd_t      cmd_reg;
    idx_t      pos_reg;
    word_t     din_reg;

    cnt_t      count_reg;
    cnt_t      count_next;
    status_t   status_reg;
    status_t   status_next;
    logic      rd_ok_reg;
    logic      rd_ok_next;

    logic               out_valid_reg;
    logic [DOUT_W-1:0]  out_data_reg;
    logic [CNTF_W-1:0]  out_count_reg;
    logic [STAT_W-1:0]  out_status_reg;

    cell_cmd_t cell_cmd;
    word_t     rd_word;
    idx_t      count_ext;
    logic      is_full;
    logic      out_free;
    logic      req_beat;
    logic      out_load;

    assign count_ext = CMP_W'(count_reg);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_beat  = req.valid && req.ready;
    assign out_load  = (state_reg == FSM_GATHER) && out_free;

    assign req.ready = (state_reg == FSM_IDLE);

    // command decode, status and the broadcast to the cells
    always_comb
    begin
        count_next    = count_reg;
        status_next   = status_reg;
        rd_ok_next    = rd_ok_reg;
        cell_cmd.op   = CELL_HOLD;
        cell_cmd.pos  = pos_reg;
        cell_cmd.data = din_reg;
        if (state_reg == FSM_EXEC)
        begin
            status_next = ST_OK;
            rd_ok_next  = 1'b0;
            case (cmd_reg)
                CMD_APPEND:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cell_cmd.op  = CELL_INSERT;
                        cell_cmd.pos = count_ext;
                        count_next   = count_reg + 1'b1;
                    end
                end
                CMD_INSERT:
                begin
                    if (pos_reg > count_ext)
                    begin
                        status_next = ST_BADIDX;
                    end
                    else if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cell_cmd.op = CELL_INSERT;
                        count_next  = count_reg + 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (pos_reg >= count_ext)
                    begin
                        status_next = ST_BADIDX;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                    end
                end
                default:
                begin
                    if (pos_reg >= count_ext)
                    begin
                        status_next = ST_BADIDX;
                    end
                    else
                    begin
                        cell_cmd.op = CELL_REMOVE;
                        count_next  = count_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_GATHER;
            end
            FSM_GATHER:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            cmd_reg <= cmd_t'(req.command);
            pos_reg <= CMP_W'(req.position);
            din_reg <= to_word(req.data_in);
        end
    end

    ilir_chain u_chain (
        .clk     (clk),
        .cmd     (cell_cmd),
        .rd_word (rd_word)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg   <= rd_ok_reg ? to_dout(rd_word) : '0;
            out_count_reg  <= CNTF_W'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = out_data_reg;
    assign rsp.item_count = out_count_reg;
    assign rsp.status     = out_status_reg;

`ifndef SYNTHESIS
    // the count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a full status only comes with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && status_reg == ST_FULL) |=> (out_count_reg == CNTF_W'(CAPACITY)))
        else $error("full status with room left");

    // a nonzero word goes out only with an ok status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data_out != '0) |-> (rsp.status == ST_OK))
        else $error("data on a failed command");

    // the count moves by at most one per command, and only in the execute step
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != FSM_EXEC) |=> $stable(count_reg))
        else $error("count changed outside execute");
`endif

endmodule
`default_nettype wire
